FILE: rtl/speed_pid_with_dynamic_antiwindup_defines.svh
// Assertion macros for the speed PID block.
// Used by the port checker; no other dependencies.
`ifndef SPEED_PID_WITH_DYNAMIC_ANTIWINDUP_DEFINES_SVH
`define SPEED_PID_WITH_DYNAMIC_ANTIWINDUP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SPWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spwd check failed");

// Next-cycle implication, disabled while in reset
`define SPWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spwd check failed");

`endif

FILE: rtl/spwd_pkg.sv
// Shared types, codes and helpers for the speed PID block.
// No dependencies.
`timescale 1ns / 1ps

package spwd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_OUT_UPPER = 3'd3;
    localparam logic [2:0] REG_OUT_LOWER = 3'd4;
    localparam logic [2:0] REG_ERR_LIMIT = 3'd5;
    localparam logic [2:0] REG_FW_ON     = 3'd6;

    // Limit flag codes
    localparam logic [1:0] LIM_NONE  = 2'd0;
    localparam logic [1:0] LIM_UPPER = 2'd1;
    localparam logic [1:0] LIM_LOWER = 2'd2;

    // Shared multiplier operand selection
    localparam logic [2:0] MUL_P   = 3'd0;
    localparam logic [2:0] MUL_I   = 3'd1;
    localparam logic [2:0] MUL_D   = 3'd2;
    localparam logic [2:0] MUL_OLD = 3'd3;
    localparam logic [2:0] MUL_NEW = 3'd4;

    typedef struct packed {
        logic signed [31:0] speed_ref;
        logic signed [31:0] speed_fbk;
    } in_t;

    typedef struct packed {
        logic signed [31:0] drive_cmd;
        logic               is_iq_cmd;
        logic [1:0]         limit_flag;
    } out_t;

    typedef struct packed {
        logic [30:0]        gain_p;
        logic [30:0]        gain_i;
        logic [30:0]        gain_d;
        logic signed [31:0] out_upper;
        logic signed [31:0] out_lower;
        logic [30:0]        err_limit;
        logic               field_weaken_on;
    } cfg_t;

    // One strobe per datapath step
    typedef struct packed {
        logic       ld_diff;
        logic       ld_err;
        logic       ld_ediff;
        logic       ld_p;
        logic       ld_inc_bnd;
        logic       ld_d_ui;
        logic       ld_int;
        logic       ld_sum;
        logic       ld_lim;
        logic       ld_fin;
        logic       mul_en;
        logic [2:0] mul_sel;
    } cmd_t;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < S32_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/spwd_cfg.sv
// Configuration register bank for the speed PID block.
// Depends on spwd_pkg.
`timescale 1ns / 1ps

module spwd_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output spwd_pkg::cfg_t  cfg
);
    import spwd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; out-of-range indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    cfg_next.gain_p = cfg_data[30:0];
                REG_GAIN_I:    cfg_next.gain_i = cfg_data[30:0];
                REG_GAIN_D:    cfg_next.gain_d = cfg_data[30:0];
                REG_OUT_UPPER: cfg_next.out_upper = cfg_data;
                REG_OUT_LOWER: cfg_next.out_lower = cfg_data;
                REG_ERR_LIMIT: cfg_next.err_limit = cfg_data[30:0];
                REG_FW_ON:     cfg_next.field_weaken_on = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/spwd_ctrl.sv
// Sequencer for the speed PID block: handshakes and datapath step strobes.
// Depends on spwd_pkg.
`timescale 1ns / 1ps

module spwd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output spwd_pkg::cmd_t cmd
);
    import spwd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_MP   = 4'd2;
    localparam logic [3:0] S_MI   = 4'd3;
    localparam logic [3:0] S_MD   = 4'd4;
    localparam logic [3:0] S_MO   = 4'd5;
    localparam logic [3:0] S_INT  = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_LIM  = 4'd8;
    localparam logic [3:0] S_MN   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Step sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ld_diff = in_valid;
                if (in_valid)
                    state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.ld_err = 1'b1;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_P;
                cmd.ld_ediff = 1'b1;
                state_next   = S_MI;
            end
            S_MI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                cmd.ld_p    = 1'b1;
                state_next  = S_MD;
            end
            S_MD:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_D;
                cmd.ld_inc_bnd = 1'b1;
                state_next     = S_MO;
            end
            S_MO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OLD;
                cmd.ld_d_ui = 1'b1;
                state_next  = S_INT;
            end
            S_INT:
            begin
                cmd.ld_int = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.ld_sum = 1'b1;
                state_next = S_LIM;
            end
            S_LIM:
            begin
                cmd.ld_lim = 1'b1;
                state_next = S_MN;
            end
            S_MN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NEW;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                // wait for the output register to be free
                cmd.ld_fin = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid: set on a finished item, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.ld_fin)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/spwd_dpath.sv
// Datapath for the speed PID block: shared multiplier, clamps, filter.
// Depends on spwd_pkg; driven by strobes from spwd_ctrl.
`timescale 1ns / 1ps

module spwd_dpath #(
    parameter int FRAC_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  spwd_pkg::cmd_t cmd,
    input  spwd_pkg::cfg_t cfg,
    input  spwd_pkg::in_t  in_data,
    output spwd_pkg::out_t out_data
);
    import spwd_pkg::*;

    // Filter weights 0.8 and 0.2 in Q(FRAC_BITS)
    localparam longint C_NEW_L = (longint'(4) << FRAC_BITS) / 5;
    localparam longint C_OLD_L = (longint'(1) << FRAC_BITS) / 5;
    localparam logic signed [32:0] C_NEW = 33'(C_NEW_L);
    localparam logic signed [32:0] C_OLD = 33'(C_OLD_L);

    // Controller state
    logic signed [31:0] prev_err_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] filt_reg;

    // Working registers
    logic signed [32:0] diff_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] ediff_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] inc_reg;
    logic signed [31:0] d_reg;
    logic signed [32:0] hi_reg;
    logic signed [32:0] lo_reg;
    logic signed [32:0] ui_reg;
    logic signed [31:0] old_reg;
    logic signed [32:0] pd_reg;
    logic signed [33:0] sum_reg;
    logic signed [31:0] slim_reg;
    logic [1:0]         flag_reg;
    out_t               out_reg;

    logic signed [32:0] lim;
    logic signed [32:0] err_next;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;
    logic signed [65:0] prod_shr;
    logic signed [31:0] qterm;
    logic               err_pos;
    logic signed [32:0] hi_next;
    logic signed [32:0] lo_next;
    logic signed [32:0] ui_clamp;
    logic signed [31:0] integ_next;
    logic signed [33:0] up34;
    logic signed [33:0] dn34;
    logic signed [31:0] slim_next;
    logic [1:0]         flag_next;
    logic signed [31:0] fin_next;

    // Error clamp to +-err_limit
    assign lim = $signed({2'b00, cfg.err_limit});
    always_comb
    begin
        if (diff_reg > lim)
            err_next = lim;
        else if (diff_reg < -lim)
            err_next = -lim;
        else
            err_next = diff_reg;
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_P:
            begin
                mul_a = $signed({2'b00, cfg.gain_p});
                mul_b = 33'(err_reg);
            end
            MUL_I:
            begin
                mul_a = $signed({2'b00, cfg.gain_i});
                mul_b = 33'(err_reg);
            end
            MUL_D:
            begin
                mul_a = $signed({2'b00, cfg.gain_d});
                mul_b = ediff_reg;
            end
            MUL_OLD:
            begin
                mul_a = C_OLD;
                mul_b = 33'(filt_reg);
            end
            MUL_NEW:
            begin
                mul_a = C_NEW;
                mul_b = 33'(slim_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_shr  = prod_reg >>> FRAC_BITS;
    assign qterm     = sat32(prod_shr);

    // Integrator bounds shrink by P in the error's direction
    assign err_pos = !err_reg[31] && (err_reg != '0);
    always_comb
    begin
        if (err_pos)
        begin
            hi_next = 33'(cfg.out_upper) - 33'(p_reg);
            if (hi_next[32])
                hi_next = '0;
            lo_next = 33'(cfg.out_lower);
        end
        else
        begin
            lo_next = 33'(cfg.out_lower) - 33'(p_reg);
            if (!lo_next[32] && (lo_next != '0))
                lo_next = '0;
            hi_next = 33'(cfg.out_upper);
        end
    end

    // Integrator clamp, upper bound first
    always_comb
    begin
        if (ui_reg > hi_reg)
            ui_clamp = hi_reg;
        else if (ui_reg < lo_reg)
            ui_clamp = lo_reg;
        else
            ui_clamp = ui_reg;
    end
    assign integ_next = sat32(66'(ui_clamp));

    // Output saturation with limit flag, upper limit first
    assign up34 = 34'(cfg.out_upper);
    assign dn34 = 34'(cfg.out_lower);
    always_comb
    begin
        if (sum_reg > up34)
        begin
            slim_next = cfg.out_upper;
            flag_next = LIM_UPPER;
        end
        else if (sum_reg < dn34)
        begin
            slim_next = cfg.out_lower;
            flag_next = LIM_LOWER;
        end
        else
        begin
            slim_next = sum_reg[31:0];
            flag_next = LIM_NONE;
        end
    end

    // Output filter sum
    assign fin_next = sat32(prod_shr + 66'(old_reg));

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
            filt_reg     <= '0;
        end
        else
        begin
            if (cmd.ld_ediff)
                prev_err_reg <= err_reg;
            if (cmd.ld_int)
                integ_reg <= integ_next;
            if (cmd.ld_fin)
                filt_reg <= fin_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.ld_diff)
            diff_reg <= 33'(in_data.speed_ref) - 33'(in_data.speed_fbk);
        if (cmd.ld_err)
            err_reg <= err_next[31:0];
        if (cmd.ld_ediff)
            ediff_reg <= 33'(err_reg) - 33'(prev_err_reg);
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.ld_p)
            p_reg <= qterm;
        if (cmd.ld_inc_bnd)
        begin
            inc_reg <= qterm;
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
        end
        if (cmd.ld_d_ui)
        begin
            d_reg  <= qterm;
            ui_reg <= 33'(integ_reg) + 33'(inc_reg);
        end
        if (cmd.ld_int)
        begin
            // 0.2 weight keeps the old term well inside 32 bits
            old_reg <= prod_shr[31:0];
            pd_reg  <= 33'(p_reg) + 33'(d_reg);
        end
        if (cmd.ld_sum)
            sum_reg <= 34'(pd_reg) + 34'(integ_reg);
        if (cmd.ld_lim)
        begin
            slim_reg <= slim_next;
            flag_reg <= flag_next;
        end
        if (cmd.ld_fin)
        begin
            out_reg.drive_cmd  <= fin_next;
            out_reg.is_iq_cmd  <= cfg.field_weaken_on;
            out_reg.limit_flag <= flag_reg;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/speed_pid_with_dynamic_antiwindup.sv
// Speed PID controller with dynamic anti-windup and output filter, top level.
// Depends on spwd_pkg, spwd_cfg, spwd_ctrl and spwd_dpath.
`timescale 1ns / 1ps

// One item is worked on at a time: after an input transfer the block stalls
// its input while the sequencer steps through ERR, MP, MI, MD, MO, INT, SUM,
// LIM, MN and FIN, and loads the result register in FIN. The sequence length
// is set by the single shared 33x33 multiplier, used in turn for the P, I, D
// and two filter products, and by the add-then-clamp steps of the error,
// integrator and output saturation, each given its own step. A finished
// result waits in the output register while the next input is taken; a
// result that is still not transferred holds the sequencer in its last step.
// Configuration writes take effect at once and belong in idle time.

module speed_pid_with_dynamic_antiwindup #(
    parameter int FRAC_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  spwd_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output spwd_pkg::out_t out_data
);
    import spwd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    spwd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spwd_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

FILE: rtl/spwd_checker.sv
// Port-level checks for the speed PID block, bound to the top level.
// Depends on spwd_pkg and speed_pid_with_dynamic_antiwindup_defines.svh.
`timescale 1ns / 1ps
`include "speed_pid_with_dynamic_antiwindup_defines.svh"

module spwd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input spwd_pkg::out_t out_data
);
    import spwd_pkg::*;

    // A held result keeps its value
    `SPWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // The flag never carries the unused code
    `SPWD_ASSERT_NOW(a_flag_code, clk, rst_n, out_valid, out_data.limit_flag != 2'd3)

    // One item at a time: a transfer makes the block busy
    `SPWD_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)

    // A new result only comes out of a busy block
    `SPWD_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind speed_pid_with_dynamic_antiwindup spwd_checker u_spwd_checker (.*);
